// ----- rtl/cfm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfm_pkg
// shared constants for the cadence frame mapper
// ----------------------------------------------------------------------------
package cfm_pkg;

  localparam int unsigned STEP_BITS = 16;
  localparam int unsigned CFG_AW    = 2;

  localparam logic [CFG_AW-1:0] REG_SOURCE_PERIOD   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_TIMELINE_PERIOD = 2'd1;
  localparam logic [CFG_AW-1:0] REG_CYCLE_PHASE     = 2'd2;

endpackage

// ----- rtl/cfm_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfm_div_cell
// one restoring division step: shifts in a dividend bit, yields a quotient bit
// ----------------------------------------------------------------------------
module cfm_div_cell #(
  parameter int unsigned NW = 8,
  parameter int unsigned DW = 4,
  parameter int unsigned TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_in,
  input  logic [DW-1:0] rem_in,
  input  logic [NW-1:0] dq_in,
  input  logic [DW-1:0] dvs,
  input  logic [TW-1:0] tag_in,
  output logic          vld_out,
  output logic [DW-1:0] rem_out,
  output logic [NW-1:0] dq_out,
  output logic [TW-1:0] tag_out
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_nxt;
  logic [NW-1:0] dq_nxt;

  always_comb begin
    trial   = {rem_in, dq_in[NW-1]};
    diff    = trial - {1'b0, dvs};
    ge      = (trial >= {1'b0, dvs});
    rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
    dq_nxt  = {dq_in[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_nxt;
      dq_out  <= dq_nxt;
      tag_out <= tag_in;
    end
  end

endmodule

// ----- rtl/cfm_udiv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfm_udiv
// pipelined unsigned divider, a row of nw division cells with a side tag
// ----------------------------------------------------------------------------
module cfm_udiv #(
  parameter int unsigned NW = 8,
  parameter int unsigned DW = 4,
  parameter int unsigned TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_in,
  input  logic [NW-1:0] dvd,
  input  logic [DW-1:0] dvs,
  input  logic [TW-1:0] tag_in,
  output logic          vld_out,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [TW-1:0] tag_out
);

  logic          vld_c [0:NW];
  logic [DW-1:0] rem_c [0:NW];
  logic [NW-1:0] dq_c  [0:NW];
  logic [TW-1:0] tag_c [0:NW];

  assign vld_c[0] = vld_in;
  assign rem_c[0] = '0;
  assign dq_c[0]  = dvd;
  assign tag_c[0] = tag_in;

  for (genvar i = 0; i < NW; i++) begin : g_cell
    cfm_div_cell #(.NW(NW), .DW(DW), .TW(TW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_in  (vld_c[i]),
      .rem_in  (rem_c[i]),
      .dq_in   (dq_c[i]),
      .dvs     (dvs),
      .tag_in  (tag_c[i]),
      .vld_out (vld_c[i+1]),
      .rem_out (rem_c[i+1]),
      .dq_out  (dq_c[i+1]),
      .tag_out (tag_c[i+1])
    );
  end

  assign vld_out = vld_c[NW];
  assign quo     = dq_c[NW];
  assign rem     = rem_c[NW];
  assign tag_out = tag_c[NW];

endmodule

// ----- rtl/cadence_frame_mapper_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cadence_frame_mapper_core
// maps a timeline frame onto the bracketing source frames of a cadence
// ----------------------------------------------------------------------------
// One transaction is taken per cycle unless the result side stalls, and every
// transaction gives one result. It passes an offset stage, a magnitude and
// product stage, a row of restoring division cells (one quotient bit per cell)
// dividing by timeline_period, a floor fixup, a magnitude stage and a second
// row dividing by timeline_period for the timestep and by source_period for the
// shown-at frames. Any stall on the result side holds the whole pipeline.
// Configuration is taken from the live registers, so write it only while no
// transaction is in flight.
module cadence_frame_mapper_core
  import cfm_pkg::*;
#(
  parameter int unsigned PERIOD_BITS = 16,
  parameter int unsigned TIME_BITS   = 32,
  localparam int unsigned IDW = ((TIME_BITS + 7) / 8) * 8,
  localparam int unsigned ODW =
    ((4 * PERIOD_BITS + 4 * TIME_BITS + 21 + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_AW-1:0]      cfg_addr,
  input  logic [PERIOD_BITS-1:0] cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IDW-1:0]         in_tdata,   // timeline_frame
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // cycle_position, source_frame_first, source_frame_second,
  // position_remainder, blend_timestep, first_shown_at, second_shown_at,
  // mapping_valid
  output logic [ODW-1:0]         out_tdata
);

  localparam int unsigned PB  = PERIOD_BITS;
  localparam int unsigned TB  = TIME_BITS;
  localparam int unsigned OW  = ((TB > PB) ? TB : PB) + 1;
  localparam int unsigned MW  = OW + PB;
  localparam int unsigned AW  = MW + 1;
  localparam int unsigned SAW = AW + 1;
  localparam int unsigned FW  = TB + PB;
  localparam int unsigned SW  = TB + 2;
  localparam int unsigned RAW = 4 * PB + 4 * TB + 21;

  logic [PB-1:0] src_r, tlp_r, phs_r;
  logic          en;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= '0;
      tlp_r <= PB'(1);
      phs_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SOURCE_PERIOD:   src_r <= cfg_wdata;
        REG_TIMELINE_PERIOD: tlp_r <= cfg_wdata;
        REG_CYCLE_PHASE:     phs_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // offset stage
  logic                 s1_vld_r;
  logic signed [OW-1:0] s1_off_r;
  logic [TB-1:0]        s1_t_r;
  logic [TB-1:0]        t_in;

  assign t_in = in_tdata[TB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (en) s1_vld_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_off_r <= $signed({{(OW-TB){t_in[TB-1]}}, t_in}) - $signed({{(OW-PB){1'b0}}, phs_r});
      s1_t_r   <= t_in;
    end
  end

  // magnitude and product stage
  logic          s2_vld_r, s2_neg_r;
  logic [OW-1:0] s2_omag_r;
  logic [MW-1:0] s2_pmag_r;
  logic [TB-1:0] s2_t_r;
  logic [OW-1:0] omag;

  assign omag = s1_off_r[OW-1] ? OW'(-s1_off_r) : OW'(s1_off_r);

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (en) s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_neg_r  <= s1_off_r[OW-1];
      s2_omag_r <= omag;
      s2_pmag_r <= MW'(omag) * MW'(src_r);
      s2_t_r    <= s1_t_r;
    end
  end

  // first division row: offset and product by timeline_period
  logic          a_vld, a_neg, b_vld;
  logic [MW-1:0] a_quo, b_quo, b_pmag;
  logic [PB-1:0] a_rem, b_rem;
  logic [TB-1:0] b_t;

  cfm_udiv #(.NW(MW), .DW(PB), .TW(1)) u_div_off (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(s2_vld_r),
    .dvd(MW'(s2_omag_r)), .dvs(tlp_r), .tag_in(s2_neg_r),
    .vld_out(a_vld), .quo(a_quo), .rem(a_rem), .tag_out(a_neg)
  );

  cfm_udiv #(.NW(MW), .DW(PB), .TW(TB + MW)) u_div_prod (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(s2_vld_r),
    .dvd(s2_pmag_r), .dvs(tlp_r), .tag_in({s2_t_r, s2_pmag_r}),
    .vld_out(b_vld), .quo(b_quo), .rem(b_rem), .tag_out({b_t, b_pmag})
  );

  // floor fixup stage
  logic                  s3_vld_r;
  logic [PB-1:0]         s3_pos_r, s3_rem_r;
  logic [FW-1:0]         s3_frame_r;
  logic signed [SAW-1:0] s3_a1_r, s3_a2_r;
  logic [TB-1:0]         s3_t_r;
  logic [PB-1:0]         pos_c, rem_c;
  logic signed [SAW-1:0] frame_c, prod_c, a1_c;

  always_comb begin
    pos_c   = (a_neg && a_rem != '0) ? PB'(tlp_r - a_rem) : a_rem;
    rem_c   = (a_neg && b_rem != '0) ? PB'(tlp_r - b_rem) : b_rem;
    frame_c = $signed({2'b00, b_quo});
    prod_c  = $signed({2'b00, b_pmag});
    if (a_neg) begin
      frame_c = -frame_c - ((b_rem != '0) ? SAW'(1) : SAW'(0));
      prod_c  = -prod_c;
    end
    a1_c = prod_c - $signed({{(SAW-PB){1'b0}}, rem_c});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else if (en) s3_vld_r <= a_vld && b_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_pos_r   <= pos_c;
      s3_rem_r   <= rem_c;
      s3_frame_r <= frame_c[FW-1:0];
      s3_a1_r    <= a1_c;
      s3_a2_r    <= a1_c + $signed({{(SAW-PB){1'b0}}, tlp_r});
      s3_t_r     <= b_t;
    end
  end

  // magnitudes for the ceiling divisions
  logic          s4_vld_r, s4_p1_r, s4_p2_r;
  logic [AW-1:0] s4_m1_r, s4_m2_r;
  logic [PB-1:0] s4_pos_r, s4_rem_r;
  logic [FW-1:0] s4_frame_r;
  logic [TB-1:0] s4_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else if (en) s4_vld_r <= s3_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_p1_r    <= !s3_a1_r[SAW-1] && (s3_a1_r != '0);
      s4_p2_r    <= !s3_a2_r[SAW-1] && (s3_a2_r != '0);
      s4_m1_r    <= s3_a1_r[SAW-1] ? AW'(-s3_a1_r) : AW'(s3_a1_r);
      s4_m2_r    <= s3_a2_r[SAW-1] ? AW'(-s3_a2_r) : AW'(s3_a2_r);
      s4_pos_r   <= s3_pos_r;
      s4_rem_r   <= s3_rem_r;
      s4_frame_r <= s3_frame_r;
      s4_t_r     <= s3_t_r;
    end
  end

  // second division row: timestep and shown-at frames
  logic          c_vld, d_vld, e_vld, d_p, e_p;
  logic [AW-1:0] c_quo, d_quo, e_quo;
  logic [PB-1:0] c_rem, d_rem, e_rem;
  logic [PB-1:0] c_pos, c_prem;
  logic [FW-1:0] c_frame;
  logic [TB-1:0] d_t;

  cfm_udiv #(.NW(AW), .DW(PB), .TW(2 * PB + FW)) u_div_step (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(s4_vld_r),
    .dvd(AW'({s4_rem_r, {STEP_BITS{1'b0}}})), .dvs(tlp_r),
    .tag_in({s4_rem_r, s4_pos_r, s4_frame_r}),
    .vld_out(c_vld), .quo(c_quo), .rem(c_rem), .tag_out({c_prem, c_pos, c_frame})
  );

  cfm_udiv #(.NW(AW), .DW(PB), .TW(TB + 1)) u_div_first (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(s4_vld_r),
    .dvd(s4_m1_r), .dvs(src_r), .tag_in({s4_p1_r, s4_t_r}),
    .vld_out(d_vld), .quo(d_quo), .rem(d_rem), .tag_out({d_p, d_t})
  );

  cfm_udiv #(.NW(AW), .DW(PB), .TW(1)) u_div_second (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(s4_vld_r),
    .dvd(s4_m2_r), .dvs(src_r), .tag_in(s4_p2_r),
    .vld_out(e_vld), .quo(e_quo), .rem(e_rem), .tag_out(e_p)
  );

  // result assembly
  logic                  map_ok;
  logic signed [SAW-1:0] ceil1, ceil2, shown1, shown2;
  logic [SW-1:0]         t_ext;
  logic [RAW-1:0]        res;

  always_comb begin
    map_ok = (src_r != '0) && (tlp_r != '0);
    ceil1  = $signed({1'b0, d_quo});
    ceil2  = $signed({1'b0, e_quo});
    if (d_p) ceil1 = ceil1 + ((d_rem != '0) ? SAW'(1) : SAW'(0));
    else     ceil1 = -ceil1;
    if (e_p) ceil2 = ceil2 + ((e_rem != '0) ? SAW'(1) : SAW'(0));
    else     ceil2 = -ceil2;
    shown1 = ceil1 + $signed({{(SAW-PB){1'b0}}, phs_r});
    shown2 = ceil2 + $signed({{(SAW-PB){1'b0}}, phs_r});
    t_ext  = {{2{d_t[TB-1]}}, d_t};
    if (map_ok) begin
      res = {1'b1, shown2[SW-1:0], shown1[SW-1:0], c_quo[STEP_BITS-1:0],
             c_prem, FW'(c_frame + FW'(1)), c_frame, c_pos};
    end else begin
      res = {1'b0, t_ext, t_ext, {(RAW - 1 - 2 * SW){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (en) out_tvalid <= c_vld && d_vld && e_vld;
  end

  always_ff @(posedge clk) begin
    if (en) out_tdata <= ODW'(res);
  end

endmodule

// ----- rtl/cfm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfm_checker
// port-level checks for the cadence frame mapper
// ----------------------------------------------------------------------------
module cfm_checker
  import cfm_pkg::*;
#(
  parameter int unsigned PERIOD_BITS = 16,
  parameter int unsigned TIME_BITS   = 32,
  localparam int unsigned ODW =
    ((4 * PERIOD_BITS + 4 * TIME_BITS + 21 + 7) / 8) * 8,
  localparam int unsigned MVB = 4 * PERIOD_BITS + 4 * TIME_BITS + 20,
  localparam int unsigned TSB = 2 * PERIOD_BITS + 2 * (TIME_BITS + PERIOD_BITS)
) (
  input logic           clk,
  input logic           rst_n,
  input logic           in_tready,
  input logic           out_tvalid,
  input logic           out_tready,
  input logic [ODW-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while result stalled");

  a_free_takes_in: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input refused with empty output");

  a_passthrough_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[MVB] |->
      out_tdata[PERIOD_BITS-1:0] == '0 &&
      out_tdata[TSB +: STEP_BITS] == '0)
    else $error("unmapped result carries nonzero fields");

endmodule

bind cadence_frame_mapper_core cfm_checker #(
  .PERIOD_BITS(PERIOD_BITS),
  .TIME_BITS  (TIME_BITS)
) u_cfm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
